FILE: rtl/ffba_pkg.sv
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared types and constants of the first-fit bitmap allocator.
// ----------------------------------------------------------------------------
package ffba_pkg;

	localparam int unsigned WORD_W   = 32;
	localparam int unsigned WORD_SH  = 5;
	localparam int unsigned IDX_W    = $clog2(WORD_W + 1);
	localparam int unsigned START_W  = 12;
	localparam int unsigned LEN_W    = 13;
	localparam int unsigned STATUS_W = 2;

	localparam logic ACT_ALLOC = 1'b0;
	localparam logic ACT_FREE  = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 2'd0,
		ST_NO_SPACE = 2'd1,
		ST_BAD      = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		CS_CLEAR,
		CS_IDLE,
		CS_CHECK,
		CS_SCAN,
		CS_MINIT,
		CS_MARK,
		CS_DONE_OK,
		CS_DONE_NOSP,
		CS_DONE_BAD
	} ctrl_state_t;

	typedef struct packed {
		logic    clear;
		logic    load;
		logic    scan_init;
		logic    scan;
		logic    mark_init;
		logic    mark;
		logic    out_load;
		status_t out_status;
	} ffba_cmd_t;

	typedef struct packed {
		logic clear_done;
		logic req_valid;
		logic bad;
		logic is_free;
		logic scan_hit;
		logic scan_miss;
		logic mark_done;
		logic out_busy;
	} ffba_sts_t;

endpackage

FILE: rtl/ffba_req_if.sv
// ----------------------------------------------------------------------------
// ffba_req_if
// Request channel: action, start slice and length with valid/ready.
// ----------------------------------------------------------------------------
interface ffba_req_if import ffba_pkg::*;;
	logic               valid;
	logic               ready;
	logic               action;
	logic [START_W-1:0] start_index;
	logic [LEN_W-1:0]   length;

	modport source (output valid, output action, output start_index, output length,
		input ready);
	modport sink (input valid, input action, input start_index, input length,
		output ready);
endinterface

FILE: rtl/ffba_rsp_if.sv
// ----------------------------------------------------------------------------
// ffba_rsp_if
// Response channel: status and start slice with valid/ready.
// ----------------------------------------------------------------------------
interface ffba_rsp_if import ffba_pkg::*;;
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [START_W-1:0]  alloc_start;

	modport source (output valid, output status, output alloc_start, input ready);
	modport sink (input valid, input status, input alloc_start, output ready);
endinterface

FILE: rtl/ffba_ram.sv
// ----------------------------------------------------------------------------
// ffba_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ffba_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 128
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: rtl/ffba_datapath.sv
// ----------------------------------------------------------------------------
// ffba_datapath
// Bitmap storage, word-wide first-fit scan, range marking and result register.
// ----------------------------------------------------------------------------
module ffba_datapath import ffba_pkg::*; #(
	parameter int unsigned NUM_SLICES = 4096
) (
	input  logic       clk,
	input  logic       arst_n,
	ffba_req_if.sink   req,
	ffba_rsp_if.source rsp,
	input  ffba_cmd_t  cmd,
	output ffba_sts_t  sts
);

	localparam int unsigned NUM_WORDS = (NUM_SLICES + WORD_W - 1) / WORD_W;
	localparam int unsigned WAW = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
	localparam int unsigned SLW = ($clog2(NUM_SLICES) > LEN_W) ? $clog2(NUM_SLICES) : LEN_W;
	localparam int unsigned CW = SLW + 1;
	localparam int unsigned LAST_BITS = NUM_SLICES - (NUM_WORDS - 1) * WORD_W;
	localparam logic [WORD_W-1:0] LAST_MASK = {WORD_W{1'b1}} >> (WORD_W - LAST_BITS);
	localparam logic [WAW:0] LAST_WORD = (WAW + 1)'(NUM_WORDS - 1);
	localparam logic [CW-1:0] NS = CW'(NUM_SLICES);
	localparam logic [CW-1:0] WORD_LEN = CW'(WORD_W);

	function automatic logic [IDX_W-1:0] lsb_idx(input logic [WORD_W-1:0] x);
		logic [WORD_W-1:0] y;
		logic [IDX_W-1:0]  idx;
		y = x & (~x + WORD_W'(1));
		idx = '0;
		for (int j = 0; j < WORD_W; j++) begin
			if (y[j]) begin
				idx = idx | IDX_W'(j);
			end
		end
		if (x == '0) begin
			idx = IDX_W'(WORD_W);
		end
		return idx;
	endfunction

	logic              action_q;
	logic [CW-1:0]     start_q;
	logic [CW-1:0]     len_q;
	logic [CW-1:0]     end_q;
	logic [CW-1:0]     run_q;
	logic [WAW:0]      rd_word_q;
	logic              pend_q;
	logic [WAW-1:0]    pw_q;
	logic              rsp_valid_q;
	status_t           rsp_status_q;
	logic [START_W-1:0] rsp_start_q;

	logic                ram_we;
	logic [WAW-1:0]      ram_waddr;
	logic [WORD_W-1:0]   ram_wdata;
	logic                issue;
	logic [WORD_W-1:0]   rdata;

	logic [CW-1:0]       base;
	logic [WORD_W-1:0]   vmask;
	logic [WORD_W-1:0]   free_bits;
	logic [WORD_W-1:0]   used_rev;
	logic [2*WORD_W-1:0] ext;
	logic [2*WORD_W-1:0] win;
	logic                short_len;
	logic [IDX_W-1:0]    short_idx;
	logic [IDX_W-1:0]    tzf;
	logic [IDX_W-1:0]    lead;
	logic [CW-1:0]       need;
	logic [CW-1:0]       need_m1;
	logic                long_hit;
	logic                hit;
	logic [WORD_SH-1:0]  hit_idx;
	logic [CW-1:0]       found;
	logic [CW-1:0]       next_run;
	logic [CW-1:0]       sum;

	logic [WAW-1:0]      first_word;
	logic [WAW-1:0]      end_word;
	logic [WORD_SH-1:0]  lo;
	logic [WORD_SH-1:0]  hi;
	logic [WORD_W-1:0]   mk_mask;
	logic [WORD_W-1:0]   mk_wdata;

	// scan of one word
	always_comb begin
		base = CW'({pw_q, {WORD_SH{1'b0}}});
		vmask = (pw_q == LAST_WORD[WAW-1:0]) ? LAST_MASK : {WORD_W{1'b1}};
		free_bits = ~rdata & vmask;
		for (int i = 0; i < WORD_W; i++) begin
			ext[i] = (run_q >= CW'(WORD_W - i));
			used_rev[i] = ~free_bits[WORD_W-1-i];
		end
		ext[2*WORD_W-1:WORD_W] = free_bits;
		win = {2*WORD_W{1'b1}};
		for (int k = 0; k < WORD_W; k++) begin
			if (CW'(k) < len_q) begin
				win = win & (ext << k);
			end
		end
		short_len = (len_q <= WORD_LEN);
		short_idx = lsb_idx(win[2*WORD_W-1:WORD_W]);
		tzf = lsb_idx(~free_bits);
		lead = lsb_idx(used_rev);
		need = len_q - run_q;
		need_m1 = need - CW'(1);
		long_hit = (need <= WORD_LEN) && (CW'(tzf) >= need);
		if (short_len) begin
			hit = |win[2*WORD_W-1:WORD_W];
			hit_idx = short_idx[WORD_SH-1:0];
		end else begin
			hit = long_hit;
			hit_idx = need_m1[WORD_SH-1:0];
		end
		found = base + CW'(hit_idx) + CW'(1) - len_q;
		next_run = (&free_bits) ? (run_q + WORD_LEN) : CW'(lead);
	end

	// range marking
	always_comb begin
		first_word = start_q[WAW+WORD_SH-1:WORD_SH];
		end_word = end_q[WAW+WORD_SH-1:WORD_SH];
		lo = (pw_q == first_word) ? start_q[WORD_SH-1:0] : '0;
		hi = (pw_q == end_word) ? end_q[WORD_SH-1:0] : WORD_SH'(WORD_W - 1);
		mk_mask = ({WORD_W{1'b1}} << lo) & ({WORD_W{1'b1}} >> (WORD_SH'(WORD_W - 1) - hi));
		mk_wdata = (action_q == ACT_ALLOC) ? (rdata | mk_mask) : (rdata & ~mk_mask);
	end

	assign sum = start_q + len_q;

	assign issue = (cmd.scan && (rd_word_q <= LAST_WORD)) ||
		(cmd.mark && (rd_word_q <= {1'b0, end_word}));
	assign ram_we = cmd.clear || (cmd.mark && pend_q);
	assign ram_waddr = cmd.clear ? rd_word_q[WAW-1:0] : pw_q;
	assign ram_wdata = cmd.clear ? '0 : mk_wdata;

	ffba_ram #(
		.WIDTH (WORD_W),
		.DEPTH (NUM_WORDS)
	) u_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (issue),
		.raddr (rd_word_q[WAW-1:0]),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_word_q <= '0;
			pend_q <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.clear) begin
				rd_word_q <= rd_word_q + (WAW + 1)'(1);
			end else if (cmd.scan_init) begin
				rd_word_q <= '0;
			end else if (cmd.mark_init) begin
				rd_word_q <= {1'b0, first_word};
			end else if (issue) begin
				rd_word_q <= rd_word_q + (WAW + 1)'(1);
			end
			pend_q <= issue;
			if (cmd.out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load && req.valid) begin
			action_q <= req.action;
			start_q <= CW'(req.start_index);
			len_q <= CW'(req.length);
		end else if (cmd.scan && pend_q && hit) begin
			start_q <= found;
		end
		if (cmd.scan_init) begin
			run_q <= '0;
		end else if (cmd.scan && pend_q && !hit) begin
			run_q <= next_run;
		end
		if (cmd.mark_init) begin
			end_q <= sum - CW'(1);
		end
		if (issue) begin
			pw_q <= rd_word_q[WAW-1:0];
		end
		if (cmd.out_load) begin
			rsp_status_q <= cmd.out_status;
			rsp_start_q <= ((cmd.out_status == ST_OK) && (action_q == ACT_ALLOC)) ?
				start_q[START_W-1:0] : '0;
		end
	end

	assign req.ready = cmd.load;
	assign rsp.valid = rsp_valid_q;
	assign rsp.status = rsp_status_q;
	assign rsp.alloc_start = rsp_start_q;

	always_comb begin
		sts.clear_done = cmd.clear && (rd_word_q == LAST_WORD);
		sts.req_valid = req.valid;
		sts.bad = (len_q == '0) ||
			((action_q == ACT_ALLOC) ? (len_q > NS) : (sum > NS));
		sts.is_free = (action_q == ACT_FREE);
		sts.scan_hit = cmd.scan && pend_q && hit;
		sts.scan_miss = cmd.scan && pend_q && !hit && (pw_q == LAST_WORD[WAW-1:0]);
		sts.mark_done = cmd.mark && pend_q && (pw_q == end_word);
		sts.out_busy = rsp_valid_q && !rsp.ready;
	end

endmodule

FILE: rtl/ffba_ctrl.sv
// ----------------------------------------------------------------------------
// ffba_ctrl
// Sequencer: clearing pass, request check, scan, marking and result hand-off.
// ----------------------------------------------------------------------------
module ffba_ctrl import ffba_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  ffba_sts_t sts,
	output ffba_cmd_t cmd
);

	ctrl_state_t state_q;
	ctrl_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CS_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			CS_CLEAR: begin
				if (sts.clear_done) begin
					state_d = CS_IDLE;
				end
			end
			CS_IDLE: begin
				if (sts.req_valid) begin
					state_d = CS_CHECK;
				end
			end
			CS_CHECK: begin
				if (sts.bad) begin
					state_d = CS_DONE_BAD;
				end else if (sts.is_free) begin
					state_d = CS_MINIT;
				end else begin
					state_d = CS_SCAN;
				end
			end
			CS_SCAN: begin
				if (sts.scan_hit) begin
					state_d = CS_MINIT;
				end else if (sts.scan_miss) begin
					state_d = CS_DONE_NOSP;
				end
			end
			CS_MINIT: begin
				state_d = CS_MARK;
			end
			CS_MARK: begin
				if (sts.mark_done) begin
					state_d = CS_DONE_OK;
				end
			end
			CS_DONE_OK, CS_DONE_NOSP, CS_DONE_BAD: begin
				if (!sts.out_busy) begin
					state_d = CS_IDLE;
				end
			end
			default: begin
				state_d = CS_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.out_status = ST_OK;
		case (state_q)
			CS_CLEAR: begin
				cmd.clear = 1'b1;
			end
			CS_IDLE: begin
				cmd.load = 1'b1;
			end
			CS_CHECK: begin
				cmd.scan_init = !sts.bad && !sts.is_free;
			end
			CS_SCAN: begin
				cmd.scan = 1'b1;
			end
			CS_MINIT: begin
				cmd.mark_init = 1'b1;
			end
			CS_MARK: begin
				cmd.mark = 1'b1;
			end
			CS_DONE_OK: begin
				cmd.out_load = !sts.out_busy;
				cmd.out_status = ST_OK;
			end
			CS_DONE_NOSP: begin
				cmd.out_load = !sts.out_busy;
				cmd.out_status = ST_NO_SPACE;
			end
			CS_DONE_BAD: begin
				cmd.out_load = !sts.out_busy;
				cmd.out_status = ST_BAD;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

FILE: rtl/first_fit_bitmap_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_bitmap_allocator
// First-fit slice allocator over a used/free bitmap.
// ----------------------------------------------------------------------------
// The map holds one bit per slice, 32 slices to a word of an internal RAM
// with one write and one registered read port. After reset a clearing pass
// writes ceil(NUM_SLICES/32) words, one per cycle, with req.ready low. One
// request is handled at a time; req.ready is high only while idle, and a
// finished result waits in the output register while the next request is
// taken. An allocate reads the map one word per cycle from word 0, then
// marks the run by read-modify-write at one word per cycle; a free does
// only the marking. A request with a bad length or range goes from the
// check straight to the result, and a finished result waits for a full
// output register to drain before it is loaded.
// ----------------------------------------------------------------------------
module first_fit_bitmap_allocator import ffba_pkg::*; #(
	parameter int unsigned NUM_SLICES = 4096
) (
	input  logic       clk,
	input  logic       arst_n,
	ffba_req_if.sink   req,
	ffba_rsp_if.source rsp
);

	ffba_cmd_t cmd;
	ffba_sts_t sts;

	ffba_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	ffba_datapath #(
		.NUM_SLICES (NUM_SLICES)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cmd    (cmd),
		.sts    (sts)
	);

`ifndef NO_ASSERTIONS
	// one request in flight
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("request taken while another is in flight");

	// start slice only reported for a successful allocate
	a_start_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && (rsp.status != ST_OK)) |-> (rsp.alloc_start == '0))
		else $error("nonzero start on failed response");

	// response held while stalled
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.ready) |=>
		(rsp.valid && $stable(rsp.status) && $stable(rsp.alloc_start)))
		else $error("response changed while stalled");
`endif

endmodule

FILE: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives allocate and free requests into the first-fit bitmap allocator and
// compares every response with a slice-map model kept alongside the block.
// A directed part covers bad lengths, bad ranges, a full map and first-fit
// hole reuse; random requests then mostly allocate runs and free live ones,
// with random stalls on both channels.
// ----------------------------------------------------------------------------

typedef struct packed {
	ffba_pkg::status_t                  status;
	logic [ffba_pkg::START_W-1:0]       start;
} alloc_rsp_t;

class slice_scoreboard #(int unsigned SLICES = 4096);
	bit          used [SLICES];
	alloc_rsp_t  pending [$];
	int unsigned live_start [$];
	int unsigned live_len [$];
	int unsigned errors;

	// first-fit search and marking for one accepted request
	function void note_request(input logic act, input logic [ffba_pkg::START_W-1:0] first,
		input logic [ffba_pkg::LEN_W-1:0] count);
		alloc_rsp_t  rsp;
		int unsigned run;
		int unsigned base;
		rsp.status = ffba_pkg::ST_BAD;
		rsp.start  = '0;
		if (act == ffba_pkg::ACT_ALLOC) begin
			if (count != 0 && count <= SLICES) begin
				rsp.status = ffba_pkg::ST_NO_SPACE;
				run = 0;
				for (int unsigned s = 0; s < SLICES; s++) begin
					run = used[s] ? 0 : run + 1;
					if (run == count) begin
						base = s + 1 - count;
						for (int unsigned k = 0; k < count; k++)
							used[base + k] = 1'b1;
						rsp.status = ffba_pkg::ST_OK;
						rsp.start  = ffba_pkg::START_W'(base);
						live_start.push_back(base);
						live_len.push_back(count);
						break;
					end
				end
			end
		end else if (count != 0 && first + count <= SLICES) begin
			for (int unsigned k = 0; k < count; k++)
				used[first + k] = 1'b0;
			rsp.status = ffba_pkg::ST_OK;
		end
		pending.push_back(rsp);
	endfunction

	function void check_response(input logic [ffba_pkg::STATUS_W-1:0] got_status,
		input logic [ffba_pkg::START_W-1:0] got_start, input longint unsigned at_ns);
		alloc_rsp_t want;
		if (pending.size() == 0) begin
			errors++;
			$display("%0d ns: unexpected response, expected none, actual status %0d alloc_start %0d",
				at_ns, got_status, got_start);
			return;
		end
		want = pending.pop_front();
		if (got_status !== want.status || got_start !== want.start) begin
			errors++;
			$display("%0d ns: status expected %0d actual %0d, alloc_start expected %0d actual %0d",
				at_ns, want.status, got_status, want.start, got_start);
		end
	endfunction
endclass

module testbench import ffba_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned SLICES      = 4096;
	localparam int unsigned CYCLE_LIMIT = 1000000;
	localparam int unsigned RANDOM_REQS = 480;

	logic clk = 1'b0;
	logic arst_n;
	bit   calm;
	int unsigned cycles;

	slice_scoreboard #(SLICES) sb;

	ffba_req_if req_ch ();
	ffba_rsp_if rsp_ch ();

	first_fit_bitmap_allocator #(
		.NUM_SLICES(SLICES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch.sink),
		.rsp(rsp_ch.source)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	always @(negedge clk) begin
		rsp_ch.ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 15);
	end

	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready)
			sb.check_response(rsp_ch.status, rsp_ch.alloc_start, $time);
	end

	// one request, held until the block takes it
	task automatic send_request(input logic act, input logic [START_W-1:0] first,
		input logic [LEN_W-1:0] count);
		@(negedge clk);
		while (!calm && $urandom_range(0, 99) < 15) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid       <= 1'b1;
		req_ch.action      <= act;
		req_ch.start_index <= first;
		req_ch.length      <= count;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		sb.note_request(act, first, count);
	endtask

	task automatic random_alloc();
		int unsigned pick;
		logic [LEN_W-1:0] count;
		pick = $urandom_range(0, 99);
		if (pick < 80)
			count = LEN_W'($urandom_range(1, 64));
		else if (pick < 95)
			count = LEN_W'($urandom_range(65, 600));
		else
			count = LEN_W'($urandom_range(601, SLICES));
		send_request(ACT_ALLOC, START_W'($urandom_range(0, SLICES - 1)), count);
	endtask

	initial begin
		int unsigned pick;
		int unsigned idx;
		logic [START_W-1:0] first;
		logic [LEN_W-1:0]   count;
		sb                 = new;
		calm               = 1'b0;
		cycles             = 0;
		arst_n             = 1'b0;
		req_ch.valid       = 1'b0;
		req_ch.action      = ACT_ALLOC;
		req_ch.start_index = '0;
		req_ch.length      = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// zero lengths, oversize lengths, ranges past the end
		send_request(ACT_ALLOC, 12'd0, 13'd0);
		send_request(ACT_FREE, 12'd0, 13'd0);
		send_request(ACT_ALLOC, 12'd0, 13'd4097);
		send_request(ACT_ALLOC, 12'd4095, 13'd8191);
		send_request(ACT_FREE, 12'd4095, 13'd2);
		send_request(ACT_FREE, 12'd4095, 13'd4096);
		// whole map, then no space left
		send_request(ACT_ALLOC, 12'd4095, 13'd4096);
		send_request(ACT_ALLOC, 12'd0, 13'd1);
		send_request(ACT_FREE, 12'd0, 13'd4096);
		// runs across word boundaries, hole too small, freeing free slices
		send_request(ACT_ALLOC, 12'd0, 13'd1);
		send_request(ACT_ALLOC, 12'd0, 13'd31);
		send_request(ACT_ALLOC, 12'd0, 13'd33);
		send_request(ACT_FREE, 12'd1, 13'd31);
		send_request(ACT_FREE, 12'd1, 13'd31);
		send_request(ACT_ALLOC, 12'd0, 13'd32);
		send_request(ACT_ALLOC, 12'd0, 13'd31);
		send_request(ACT_FREE, 12'd4095, 13'd1);
		send_request(ACT_ALLOC, 12'd0, 13'd4000);
		send_request(ACT_ALLOC, 12'd0, 13'd3999);
		send_request(ACT_FREE, 12'd4095, 13'd1);
		send_request(ACT_ALLOC, 12'd0, 13'd1);
		send_request(ACT_FREE, 12'd0, 13'd4096);

		for (int unsigned n = 0; n < RANDOM_REQS; n++) begin
			calm = (n >= 250 && n < 350);
			pick = $urandom_range(0, 99);
			if (pick < 10) begin
				// noise: any action, any range
				first = START_W'($urandom_range(0, SLICES - 1));
				if ($urandom_range(0, 1))
					count = LEN_W'($urandom_range(0, 8191));
				else
					count = LEN_W'($urandom_range(0, 16));
				send_request(logic'($urandom_range(0, 1)), first, count);
			end else if (sb.live_len.size() != 0 && (pick < 50 || sb.live_len.size() > 40)) begin
				idx   = $urandom_range(0, sb.live_len.size() - 1);
				first = START_W'(sb.live_start[idx]);
				count = LEN_W'(sb.live_len[idx]);
				sb.live_start.delete(idx);
				sb.live_len.delete(idx);
				send_request(ACT_FREE, first, count);
			end else begin
				random_alloc();
			end
		end
		calm = 1'b0;

		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
		if (sb.errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule

FILE: first_fit_bitmap_allocator.f
rtl/ffba_pkg.sv
rtl/ffba_req_if.sv
rtl/ffba_rsp_if.sv
rtl/ffba_ram.sv
rtl/ffba_datapath.sv
rtl/ffba_ctrl.sv
rtl/first_fit_bitmap_allocator.sv
test/testbench.sv
